// File: rtl/ssr_pkg.sv
package ssr_pkg;

  localparam int DEF_SPRITE_SLOTS = 64;
  localparam int LINE_BYTES       = 32;
  localparam int TILE_ROWS        = 8;
  localparam int BYTE_IDX_W       = $clog2(LINE_BYTES);

  typedef enum logic [2:0] {
    ACT_CREATE   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_SET_X    = 3'd2,
    ACT_SET_Y    = 3'd3,
    ACT_SET_TILE = 3'd4,
    ACT_RENDER   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  slot;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [63:0] tile_bits;
    logic [7:0]  line_number;
  } in_t;

  typedef struct packed {
    logic [7:0]            line_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic                  last;
    logic [5:0]            slot_out;
    logic [1:0]            status;
  } out_t;

  // one sprite row contribution, broadcast to the line cells
  typedef struct packed {
    logic                  vld;
    logic [7:0]            hi;
    logic [7:0]            lo;
    logic [BYTE_IDX_W-1:0] chunk;
    logic                  lo_en;
  } blit_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: rtl/ssr_blit.sv
module ssr_blit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_vld_i,
  input  logic [7:0]          col_i,
  input  logic [7:0]          row_i,
  input  logic [63:0]         tile_i,
  input  logic [7:0]          line_i,
  output ssr_pkg::blit_t      blit_o
);

  logic [8:0]  diff;
  logic        hit;
  logic [2:0]  r;
  logic [7:0]  bits;
  logic [15:0] spread;
  logic                           vld_q;
  logic [7:0]                     hi_q;
  logic [7:0]                     lo_q;
  logic [ssr_pkg::BYTE_IDX_W-1:0] chunk_q;
  logic                           lo_en_q;

  // sprite covers this line when 0 <= line - top < 8
  assign diff   = {1'b0, line_i} - {1'b0, row_i};
  assign hit    = !diff[8] && (diff[7:3] == 5'd0);
  assign r      = diff[2:0];
  assign bits   = tile_i[{r, 3'b000} +: 8];
  // upper byte lands in the sprite's chunk, lower byte spills to the right
  assign spread = {bits, 8'h00} >> col_i[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rd_vld_i && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= spread[15:8];
    lo_q    <= spread[7:0];
    chunk_q <= ~col_i[7:3];
    lo_en_q <= (~col_i[7:3] != '0);
  end

  assign blit_o = {vld_q, hi_q, lo_q, chunk_q, lo_en_q};

endmodule

// File: rtl/ssr_line_cell.sv
module ssr_line_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssr_pkg::cell_ctrl_t                 ctrl_i,
  input  ssr_pkg::blit_t                      blit_i,
  input  logic [ssr_pkg::BYTE_IDX_W-1:0]      cell_idx_i,
  input  logic [7:0]                          prev_i,
  output logic [7:0]                          byte_o
);

  logic [7:0] byte_q;
  logic [7:0] hit_bits;
  logic [ssr_pkg::BYTE_IDX_W-1:0] idx_next;

  assign idx_next = cell_idx_i + 1'b1;
  assign hit_bits = ((blit_i.chunk == cell_idx_i) ? blit_i.hi : 8'h00)
                  | ((blit_i.lo_en && (blit_i.chunk == idx_next)) ? blit_i.lo : 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (ctrl_i.clear) begin
      byte_q <= 8'h00;
    end else if (ctrl_i.shift) begin
      byte_q <= prev_i;
    end else if (blit_i.vld) begin
      byte_q <= byte_q | hit_bits;
    end
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/sprite_scanline_renderer.sv
// sprite scanline renderer
// table of SPRITE_SLOTS one-bit 8x8 sprites and a 256-pixel line buffer
// held in a chain of 32 byte cells.
// input channel: in_valid_i / in_stall_o with one in_t command per transfer;
//   the block takes one command at a time and stalls input until that
//   command's results are all in the output register.
// output channel: out_valid_o / out_stall_i with one out_t result per transfer.
// delete, set x, set y, set tile and unknown codes: one result, passed
//   through the reply state into the output register.
// create: the free-slot search tests one slot per cycle, then the reply
//   state gives its single result.
// render: clears the cells, reads the sprite memory one slot per cycle,
//   then 32 byte results, leftmost first (byte_index 31 down to 0), last on
//   index 0; the bytes shift out of the cell chain one per cycle while
//   the receiver does not stall.
// when the receiver stalls, the output register holds its result and the
//   cell chain does not shift; nothing is dropped.
// reset: all slots free, line cells zero, no result pending; the sprite
//   position and tile memories are not cleared and need no clearing pass.
module sprite_scanline_renderer #(
  parameter int SPRITE_SLOTS = ssr_pkg::DEF_SPRITE_SLOTS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ssr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ssr_pkg::out_t out_data_o
);

  localparam int SLOT_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int IDX_W  = ssr_pkg::BYTE_IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SCAN,
    S_DRAIN,
    S_EMIT,
    S_REPLY
  } state_e;

  state_e             state_q;
  ssr_pkg::in_t       req_q;
  logic [SLOT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]   emit_q;
  logic [SPRITE_SLOTS-1:0] used_q;
  logic               out_valid_q;
  ssr_pkg::out_t      out_q;
  logic [5:0]         resp_slot_q;
  logic [1:0]         resp_status_q;

  // sprite memories, undefined until written
  logic [7:0]  col_mem  [SPRITE_SLOTS];
  logic [7:0]  row_mem  [SPRITE_SLOTS];
  logic [63:0] tile_mem [SPRITE_SLOTS];
  logic [7:0]  rd_col_q;
  logic [7:0]  rd_row_q;
  logic [63:0] rd_tile_q;
  logic        rd_vld_q;

  logic              accept;
  logic              out_free;
  logic [SLOT_W+5:0] slot_wide;
  logic              slot_in_range;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_valid;
  logic [SLOT_W+5:0] cnt_wide;
  logic              cnt_last;
  logic              find_hit;

  logic              we_col;
  logic              we_row;
  logic              we_tile;
  logic [SLOT_W-1:0] wr_addr;
  logic [7:0]        wr_col;
  logic [7:0]        wr_row;
  logic [63:0]       wr_tile;

  ssr_pkg::blit_t      blit;
  ssr_pkg::cell_ctrl_t cell_ctrl;
  logic [7:0]          cell_byte [ssr_pkg::LINE_BYTES];

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // slot numbers at or past the table size count as not in use
  assign slot_wide     = {{SLOT_W{1'b0}}, in_data_i.slot};
  assign slot_in_range = slot_wide < (SLOT_W + 6)'(SPRITE_SLOTS);
  assign slot_idx      = slot_wide[SLOT_W-1:0];
  assign slot_valid    = slot_in_range && used_q[slot_idx];

  assign cnt_wide = {6'b0, cnt_q};
  assign cnt_last = (cnt_q == SLOT_W'(SPRITE_SLOTS - 1));
  assign find_hit = (state_q == S_FIND) && !used_q[cnt_q];

  // memory write port: create writes all fields, the setters one each
  always_comb begin
    we_col  = 1'b0;
    we_row  = 1'b0;
    we_tile = 1'b0;
    if (find_hit) begin
      we_col  = 1'b1;
      we_row  = 1'b1;
      we_tile = 1'b1;
    end else if (accept && slot_valid) begin
      case (in_data_i.action)
        ssr_pkg::ACT_SET_X:    we_col  = 1'b1;
        ssr_pkg::ACT_SET_Y:    we_row  = 1'b1;
        ssr_pkg::ACT_SET_TILE: we_tile = 1'b1;
        default:               ;
      endcase
    end
  end

  assign wr_addr = (state_q == S_FIND) ? cnt_q : slot_idx;
  assign wr_col  = (state_q == S_FIND) ? req_q.x_pos     : in_data_i.x_pos;
  assign wr_row  = (state_q == S_FIND) ? req_q.y_pos     : in_data_i.y_pos;
  assign wr_tile = (state_q == S_FIND) ? req_q.tile_bits : in_data_i.tile_bits;

  always_ff @(posedge clk_i) begin
    if (we_col) begin
      col_mem[wr_addr] <= wr_col;
    end
    if (we_row) begin
      row_mem[wr_addr] <= wr_row;
    end
    if (we_tile) begin
      tile_mem[wr_addr] <= wr_tile;
    end
    rd_col_q  <= col_mem[cnt_q];
    rd_row_q  <= row_mem[cnt_q];
    rd_tile_q <= tile_mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN) && used_q[cnt_q];
    end
  end

  // control sequencer with the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      emit_q        <= '0;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
      req_q         <= '0;
      out_q         <= '0;
      resp_slot_q   <= '0;
      resp_status_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q         <= in_data_i;
            cnt_q         <= '0;
            resp_slot_q   <= '0;
            resp_status_q <= ssr_pkg::ST_OK;
            case (in_data_i.action)
              ssr_pkg::ACT_CREATE: state_q <= S_FIND;
              ssr_pkg::ACT_RENDER: state_q <= S_SCAN;
              ssr_pkg::ACT_DELETE,
              ssr_pkg::ACT_SET_X,
              ssr_pkg::ACT_SET_Y,
              ssr_pkg::ACT_SET_TILE: begin
                resp_slot_q <= in_data_i.slot;
                if (!slot_valid) begin
                  resp_status_q <= ssr_pkg::ST_UNUSED;
                end else if (in_data_i.action == ssr_pkg::ACT_DELETE) begin
                  used_q[slot_idx] <= 1'b0;
                end
                state_q <= S_REPLY;
              end
              default: state_q <= S_REPLY;
            endcase
          end
        end
        S_FIND: begin
          if (!used_q[cnt_q]) begin
            used_q[cnt_q] <= 1'b1;
            resp_slot_q   <= cnt_wide[5:0];
            state_q       <= S_REPLY;
          end else if (cnt_last) begin
            resp_status_q <= ssr_pkg::ST_FULL;
            state_q       <= S_REPLY;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          // memory read stage and blit stage empty out
          if (cnt_q[0]) begin
            emit_q  <= IDX_W'(ssr_pkg::LINE_BYTES - 1);
            state_q <= S_EMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.line_byte  <= cell_byte[ssr_pkg::LINE_BYTES-1];
            out_q.byte_index <= emit_q;
            out_q.last       <= (emit_q == '0);
            out_q.slot_out   <= '0;
            out_q.status     <= ssr_pkg::ST_OK;
            emit_q           <= emit_q - 1'b1;
            if (emit_q == '0) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.line_byte  <= '0;
            out_q.byte_index <= '0;
            out_q.last       <= 1'b1;
            out_q.slot_out   <= resp_slot_q;
            out_q.status     <= resp_status_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // row contribution of the sprite just read
  ssr_blit u_blit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_vld_i (rd_vld_q),
    .col_i    (rd_col_q),
    .row_i    (rd_row_q),
    .tile_i   (rd_tile_q),
    .line_i   (req_q.line_number),
    .blit_o   (blit)
  );

  // cells clear at render start and shift toward the leftmost cell on output
  assign cell_ctrl.clear = accept && (in_data_i.action == ssr_pkg::ACT_RENDER);
  assign cell_ctrl.shift = (state_q == S_EMIT) && out_free;

  for (genvar i = 0; i < ssr_pkg::LINE_BYTES; i++) begin : g_cell
    logic [7:0] prev;
    if (i == 0) begin : g_head
      assign prev = 8'h00;
    end else begin : g_link
      assign prev = cell_byte[i-1];
    end
    ssr_line_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .blit_i     (blit),
      .cell_idx_i (IDX_W'(i)),
      .prev_i     (prev),
      .byte_o     (cell_byte[i])
    );
  end

  // error results are always single transfers
  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ssr_pkg::ST_OK) |-> out_data_o.last)
    else $error("error result without last");

  // only the rightmost byte of a line closes a render
  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.byte_index != '0) |-> !out_data_o.last)
    else $error("last flag on a non-final line byte");

  // slot table does not change while a line is being rendered
  a_used_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(used_q))
    else $error("slot table changed during render scan");

  // sprite contributions only arrive during the scan and its drain
  a_blit_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blit.vld |-> (state_q == S_SCAN) || (state_q == S_DRAIN))
    else $error("sprite contribution outside render scan");

endmodule
